// ===== sv/frrs_pkg.sv =====
// package for the feedback round-robin scheduler
// types, codes and default sizes; no dependencies
package frrs_pkg;

	localparam int STORE_DEPTH_DEF = 16;
	localparam int SEQ_SLOTS_DEF = 16;

	localparam int ID_W = 16;
	localparam int LVL_W = 4;
	localparam int TIME_W = 16;
	localparam int ENTRY_W = ID_W + LVL_W + TIME_W;

	typedef enum logic [2:0] {
		ST_DISPATCH = 3'd0,
		ST_FINISH   = 3'd1,
		ST_IDLE     = 3'd2,
		ST_ADMIT    = 3'd3,
		ST_DROP     = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		REG_QUANTUM  = 2'd0,
		REG_MAXLEVEL = 2'd1,
		REG_SEQ      = 2'd2,
		REG_SEQLEN   = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_READK,
		S_SHIFT,
		S_TAIL,
		S_OUT
	} state_t;

endpackage

// ===== sv/feedback_round_robin_scheduler_top.sv =====
// top level of the feedback round-robin scheduler
// entry store in one synchronous memory, sequencer for scan, shift and tail write
// depends on frrs_pkg
//
// channel | dir | fields (low bit first)
// s_axis  | in  | tdata: req_type, proc_id, start_level, exec_time (+3 zero bits)
// m_axis  | out | tdata: status, out_id, out_level, out_remaining, occupancy (+4 zero bits)
// cfg     | in  | wr_en, wr_index, wr_data (64 bits)
//
// admit, drop or idle tick: S_IDLE goes to S_OUT, which sets the output word valid.
// a tick runs the scan of the N stored entries, the pick read, compaction above the
// pick, tail write and output, set by the single memory port passes over the store.
// one word in flight; a finished word waits in the output register, and the next input
// word is taken from the cycle after the result word is taken.
// reset clears state, counters and valid flags; memory is undefined until written.
module feedback_round_robin_scheduler_top
	import frrs_pkg::*;
#(
	parameter int STORE_DEPTH = STORE_DEPTH_DEF,
	parameter int SEQ_SLOTS = SEQ_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // req_type, proc_id, start_level, exec_time
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // status, out_id, out_level, out_remaining, occupancy
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [63:0] wr_data
);

	localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int CW = $clog2(STORE_DEPTH + 1);
	localparam int SW = (SEQ_SLOTS > 1) ? $clog2(SEQ_SLOTS) : 1;

	logic [7:0]  quantum_q;
	logic [3:0]  max_level_q;
	logic [63:0] seq_q;
	logic [4:0]  seq_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= 8'd1;
			max_level_q <= 4'd3;
			seq_q <= '0;
			seq_len_q <= 5'd1;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_QUANTUM:  quantum_q <= wr_data[7:0];
				REG_MAXLEVEL: max_level_q <= wr_data[3:0];
				REG_SEQ:      seq_q <= wr_data;
				REG_SEQLEN:   seq_len_q <= wr_data[4:0];
				default: ;
			endcase
		end
	end

	// entry memory
	logic [ENTRY_W-1:0] mem [STORE_DEPTH];
	logic               mem_we;
	logic [AW-1:0]      mem_waddr, mem_raddr;
	logic [ENTRY_W-1:0] mem_wdata, mem_rdata_q;

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		mem_rdata_q <= mem[mem_raddr];
	end

	state_t state_q, state_d;
	logic [CW-1:0] count_q;
	logic [SW-1:0] slot_q;
	logic [CW-1:0] idx_q;       // read address counter
	logic [CW-1:0] best_q;
	logic          found_q;
	logic [3:0]    best_lv_q;
	logic [3:0]    start_q;
	logic [4:0]    top_q;
	logic          rd_vld_q;
	logic [CW-1:0] rd_idx_q;
	logic [ENTRY_W-1:0] pick_q;
	logic [2:0]    o_status_q;
	logic [15:0]   o_id_q, o_time_q;
	logic [3:0]    o_lvl_q;
	logic [CW-1:0] o_cnt_q;
	logic          o_valid_q;

	logic        req_type;
	logic [15:0] in_id, in_time;
	logic [3:0]  in_lvl;
	assign req_type = s_axis_tdata[0];
	assign in_id = s_axis_tdata[16:1];
	assign in_lvl = s_axis_tdata[20:17];
	assign in_time = s_axis_tdata[36:21];

	logic accept;
	assign s_axis_tready = (state_q == S_IDLE) && !o_valid_q;
	assign accept = s_axis_tvalid && s_axis_tready;

	logic [4:0] eff_len;
	always_comb begin
		eff_len = (seq_len_q == 5'd0) ? 5'd1 : seq_len_q;
		if (eff_len > 5'(SEQ_SLOTS)) eff_len = 5'(SEQ_SLOTS);
	end

	logic [SW-1:0] slot_eff;
	assign slot_eff = ({{(5-SW){1'b0}}, slot_q} >= eff_len) ? '0 : slot_q;
	logic [3:0] start_lv;
	assign start_lv = seq_q[{2'b00, slot_eff} * 4 +: 4];

	// scan fields of the returned entry
	logic [3:0]  rd_lvl;
	logic [15:0] rd_id, rd_time;
	assign rd_id = mem_rdata_q[15:0];
	assign rd_lvl = mem_rdata_q[19:16];
	assign rd_time = mem_rdata_q[35:20];

	logic scan_hit;
	assign scan_hit = rd_vld_q && (start_q != 4'd0) && (rd_lvl >= start_q)
		&& ({1'b0, rd_lvl} <= top_q) && (!found_q || rd_lvl < best_lv_q);

	logic scan_done, shift_done;
	assign scan_done = (idx_q == count_q) && !rd_vld_q;
	assign shift_done = (idx_q == count_q) && !rd_vld_q;

	// requeue values
	logic [15:0] new_time;
	logic [3:0]  new_lvl;
	logic [15:0] pk_id, pk_time;
	logic [3:0]  pk_lvl;
	assign pk_id = pick_q[15:0];
	assign pk_lvl = pick_q[19:16];
	assign pk_time = pick_q[35:20];
	assign new_time = (pk_time > {8'd0, quantum_q}) ? pk_time - {8'd0, quantum_q} : 16'd0;
	assign new_lvl = (pk_lvl <= max_level_q && pk_lvl != 4'd15) ? pk_lvl + 4'd1 : pk_lvl;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (accept) begin
				if (!req_type || count_q == '0) state_d = S_OUT;
				else state_d = S_SCAN;
			end
			S_SCAN: if (scan_done) state_d = S_READK;
			S_READK: if (rd_vld_q) state_d = S_SHIFT;
			S_SHIFT: if (shift_done) state_d = S_TAIL;
			S_TAIL: state_d = S_OUT;
			S_OUT: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		mem_we = 1'b0;
		mem_waddr = count_q[AW-1:0];
		mem_wdata = {in_time, in_lvl, in_id};
		mem_raddr = idx_q[AW-1:0];
		unique case (state_q)
			S_IDLE: begin
				mem_we = accept && !req_type && (count_q < CW'(STORE_DEPTH));
			end
			S_READK: mem_raddr = best_q[AW-1:0];
			S_SHIFT: begin
				mem_we = rd_vld_q;
				mem_waddr = rd_idx_q[AW-1:0] - AW'(1);
				mem_wdata = mem_rdata_q;
			end
			S_TAIL: begin
				mem_we = (pk_time != 16'd0);
				mem_waddr = count_q[AW-1:0] - AW'(1);
				mem_wdata = {new_time, new_lvl, pk_id};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			slot_q <= '0;
			idx_q <= '0;
			rd_vld_q <= 1'b0;
			found_q <= 1'b0;
			o_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (m_axis_tvalid && m_axis_tready) o_valid_q <= 1'b0;
			rd_vld_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (accept) begin
					o_id_q <= in_id;
					o_lvl_q <= in_lvl;
					o_time_q <= in_time;
					idx_q <= '0;
					found_q <= 1'b0;
					best_q <= '0;
					start_q <= start_lv;
					top_q <= ({1'b0, max_level_q} + 5'd1 < {1'b0, start_lv}) ?
						{1'b0, start_lv} : {1'b0, max_level_q} + 5'd1;
					if (!req_type) begin
						if (count_q < CW'(STORE_DEPTH)) begin
							count_q <= count_q + CW'(1);
							o_status_q <= ST_ADMIT;
						end else o_status_q <= ST_DROP;
					end else if (count_q == '0) begin
						o_status_q <= ST_IDLE;
						o_id_q <= '0;
						o_lvl_q <= '0;
						o_time_q <= '0;
					end else begin
						slot_q <= slot_eff;
					end
				end
				S_SCAN: begin
					if (idx_q != count_q) begin
						idx_q <= idx_q + CW'(1);
						rd_vld_q <= 1'b1;
					end
					rd_idx_q <= idx_q;
					if (scan_hit) begin
						found_q <= 1'b1;
						best_q <= rd_idx_q;
						best_lv_q <= rd_lvl;
					end
				end
				S_READK: begin
					rd_vld_q <= !rd_vld_q;
					if (rd_vld_q) begin
						pick_q <= mem_rdata_q;
						idx_q <= best_q + CW'(1);
					end
				end
				S_SHIFT: begin
					if (idx_q != count_q) begin
						idx_q <= idx_q + CW'(1);
						rd_vld_q <= 1'b1;
					end
					rd_idx_q <= idx_q;
				end
				S_TAIL: begin
					o_id_q <= pk_id;
					if (pk_time == 16'd0) begin
						o_status_q <= ST_FINISH;
						o_lvl_q <= pk_lvl;
						o_time_q <= 16'd0;
						count_q <= count_q - CW'(1);
					end else begin
						o_status_q <= ST_DISPATCH;
						o_lvl_q <= new_lvl;
						o_time_q <= new_time;
						slot_q <= ({1'b0, slot_q} + 5'd1 >= eff_len) ? '0 :
							slot_q + SW'(1);
					end
				end
				S_OUT: begin
					o_valid_q <= 1'b1;
					o_cnt_q <= count_q;
				end
				default: ;
			endcase
		end
	end

	assign m_axis_tvalid = o_valid_q;
	assign m_axis_tdata = {4'd0, 5'(o_cnt_q), o_time_q, o_lvl_q, o_id_q, o_status_q};

endmodule
